### hdl/psjt_pkg.sv
`default_nettype none
package psjt_pkg;

	// fixed field widths
	localparam int NUM_JOINTS  = 7;
	localparam int POS_W       = 26;
	localparam int FRAC_OUT_W  = 17;
	localparam int PHASE_W     = 17;
	localparam int HALF_W      = 16;

	// stream widths
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 200;

	// configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 26;
	localparam logic [CFG_ADDR_W-1:0] CFG_HALF_PERIOD = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_JOINT0      = 3'd1;
	localparam logic [HALF_W-1:0]     HALF_RESET      = 16'd500;

	// parameter defaults
	localparam int DEF_JOINT_COUNT   = 7;
	localparam int DEF_FRACTION_BITS = 16;

	// multiply sequence steps
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_A2     = 4'd0;
	localparam logic [STEP_W-1:0] STEP_A3     = 4'd1;
	localparam logic [STEP_W-1:0] STEP_T2     = 4'd2;
	localparam logic [STEP_W-1:0] STEP_S      = 4'd3;
	localparam logic [STEP_W-1:0] STEP_JOINT0 = 4'd4;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_MUL  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

endpackage
`default_nettype wire

### hdl/psjt_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle
// quotient = floor((dividend << FRACTION_BITS) / divisor)
module psjt_div #(
	parameter int FRACTION_BITS = psjt_pkg::DEF_FRACTION_BITS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [psjt_pkg::PHASE_W-1:0] dividend,
	input  wire logic [psjt_pkg::HALF_W-1:0]  divisor,
	output logic                              done,
	output logic [psjt_pkg::PHASE_W+FRACTION_BITS-1:0] quotient
);

	localparam int QW = psjt_pkg::PHASE_W + FRACTION_BITS;
	localparam int VW = psjt_pkg::HALF_W;
	localparam int CW = $clog2(QW);

	logic [QW-1:0] num_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] div_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW:0]   trial;
	logic          ge;

	assign trial = {rem_q, num_q[QW-1]};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {dividend, {FRACTION_BITS{1'b0}}};
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[QW-2:0], ge};
			rem_q <= ge ? VW'(trial - {1'b0, div_q}) : trial[VW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule
`default_nettype wire

### hdl/pingpong_smoothstep_joint_trajectory_top.sv
`default_nettype none
// a run-high beat passes through the bit-serial divider, then the single shared multiplier,
//   each multiply having an issue phase and a write-back phase, before its result beat
// s_axis_tready stays low from an accepted run-high beat until its result is loaded into the
//   output register, which waits while the previous result still sits there; a run-low beat
//   only advances the phase counter and leaves s_axis_tready high
// reset: arst_n is asynchronous, active low; clears the phase counter, restores half period
//   500 and zero targets, drops both tvalid/busy flags
module pingpong_smoothstep_joint_trajectory_top #(
	parameter int JOINT_COUNT   = psjt_pkg::DEF_JOINT_COUNT,
	parameter int FRACTION_BITS = psjt_pkg::DEF_FRACTION_BITS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration write port
	input  wire logic                              cfg_we,
	input  wire logic [psjt_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  wire logic [psjt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	// tick stream
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  wire logic [psjt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [0] run, rest zero
	// command stream
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// [25:0] joint0_position, [51:26] joint1_position, [77:52] joint2_position,
	// [103:78] joint3_position, [129:104] joint4_position, [155:130] joint5_position,
	// [181:156] joint6_position, [198:182] smooth_fraction, [199] zero
	output logic [psjt_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);

	localparam int F   = FRACTION_BITS;
	localparam int QW  = psjt_pkg::PHASE_W + F;
	localparam int PW  = psjt_pkg::POS_W;
	// multiplier operand width: covers targets and intermediates up to -15.0 in Q.F
	localparam int MW  = (F + 6 > PW) ? F + 6 : PW;
	localparam int SH_R = (F >= 16) ? F - 16 : 0;
	localparam int SH_L = (F < 16) ? 16 - F : 0;
	localparam logic [F:0]              ONE   = (F+1)'(1) << F;
	localparam logic signed [MW-1:0]    C15   = MW'(15) << F;
	localparam logic signed [MW-1:0]    C10   = MW'(10) << F;
	localparam logic [psjt_pkg::STEP_W-1:0] LAST =
		psjt_pkg::STEP_W'(int'(psjt_pkg::STEP_JOINT0) + JOINT_COUNT - 1);

	// configuration registers
	logic [psjt_pkg::HALF_W-1:0]   half_q;
	logic signed [PW-1:0]          tgt_q [psjt_pkg::NUM_JOINTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= psjt_pkg::HALF_RESET;
			for (int i = 0; i < psjt_pkg::NUM_JOINTS; i++) begin
				tgt_q[i] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_addr == psjt_pkg::CFG_HALF_PERIOD) begin
				half_q <= cfg_wdata[psjt_pkg::HALF_W-1:0];
			end
			for (int i = 0; i < psjt_pkg::NUM_JOINTS; i++) begin
				if (cfg_addr == psjt_pkg::CFG_ADDR_W'(int'(psjt_pkg::CFG_JOINT0) + i)) begin
					tgt_q[i] <= cfg_wdata;
				end
			end
		end
	end

	// phase counter, read then advanced on every accepted tick
	psjt_pkg::state_t              state_q;
	logic [psjt_pkg::PHASE_W-1:0]  phase_q;
	logic [psjt_pkg::HALF_W-1:0]   h_eff;
	logic                          rise;
	logic [psjt_pkg::PHASE_W-1:0]  div_num;
	logic [psjt_pkg::PHASE_W:0]    phase_inc;
	logic                          in_beat;
	logic                          div_start;
	logic                          div_done;
	logic [QW-1:0]                 div_quot;

	assign h_eff     = (half_q == '0) ? psjt_pkg::HALF_W'(1) : half_q;
	assign rise      = phase_q < {1'b0, h_eff};
	assign div_num   = rise ? phase_q : phase_q - {1'b0, h_eff};
	assign phase_inc = {1'b0, phase_q} + 1'b1;
	assign s_axis_tready = (state_q == psjt_pkg::ST_IDLE);
	assign in_beat   = s_axis_tvalid && s_axis_tready;
	assign div_start = in_beat && s_axis_tdata[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (in_beat) begin
			// wrap at twice the half period
			if (phase_inc >= {1'b0, h_eff, 1'b0}) begin
				phase_q <= '0;
			end else begin
				phase_q <= phase_inc[psjt_pkg::PHASE_W-1:0];
			end
		end
	end

	psjt_div #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (h_eff),
		.done     (div_done),
		.quotient (div_quot)
	);

	// datapath registers
	logic                          rise_q;
	logic [F:0]                    a_q;
	logic signed [MW-1:0]          r_q;   // a^2, then a^3
	logic signed [MW-1:0]          t_q;   // 10 + a*(-15 + 6a)
	logic [F:0]                    s_q;
	logic signed [PW-1:0]          pos_q [psjt_pkg::NUM_JOINTS];
	logic [psjt_pkg::STEP_W-1:0]   step_q;
	logic                          ph_q;  // 0 issue multiply, 1 write back
	logic signed [2*MW-1:0]        prod_s1;
	logic                          out_valid_q;
	logic [psjt_pkg::OUT_TDATA_W-1:0] out_data_q;
	logic                          out_load;

	// output register free or being drained this cycle
	assign out_load = (state_q == psjt_pkg::ST_OUT) && (!out_valid_q || m_axis_tready);

	// shared multiplier operand select
	logic signed [MW-1:0]          a_ext;
	logic signed [MW-1:0]          s_ext;
	logic signed [MW-1:0]          t1;
	logic signed [MW-1:0]          op_a;
	logic signed [MW-1:0]          op_b;
	logic signed [MW-1:0]          sh;
	logic [2:0]                    jidx;

	assign a_ext = MW'(a_q);
	assign s_ext = MW'(s_q);
	assign t1    = (a_ext <<< 2) + (a_ext <<< 1) - C15;
	assign jidx  = 3'(step_q - psjt_pkg::STEP_JOINT0);
	// floor rescale of the product
	assign sh    = prod_s1[F +: MW];

	always_comb begin
		case (step_q)
			psjt_pkg::STEP_A2: begin
				op_a = a_ext;
				op_b = a_ext;
			end
			psjt_pkg::STEP_A3: begin
				op_a = r_q;
				op_b = a_ext;
			end
			psjt_pkg::STEP_T2: begin
				op_a = a_ext;
				op_b = t1;
			end
			psjt_pkg::STEP_S: begin
				op_a = r_q;
				op_b = t_q;
			end
			default: begin
				op_a = MW'(tgt_q[jidx]);
				op_b = s_ext;
			end
		endcase
	end

	// smoothed fraction rescaled to Q1.16
	logic [F+16:0]                 s_wide;
	logic [psjt_pkg::FRAC_OUT_W-1:0] frac;

	assign s_wide = (F+17)'(s_q) << SH_L;
	assign frac   = psjt_pkg::FRAC_OUT_W'(s_wide >> SH_R);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= psjt_pkg::ST_IDLE;
			step_q      <= '0;
			ph_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				psjt_pkg::ST_IDLE: begin
					if (div_start) begin
						state_q <= psjt_pkg::ST_DIV;
					end
				end
				psjt_pkg::ST_DIV: begin
					if (div_done) begin
						state_q <= psjt_pkg::ST_MUL;
						step_q  <= psjt_pkg::STEP_A2;
						ph_q    <= 1'b0;
					end
				end
				psjt_pkg::ST_MUL: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						if (step_q == LAST) begin
							state_q <= psjt_pkg::ST_OUT;
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
				end
				psjt_pkg::ST_OUT: begin
					if (out_load) begin
						state_q <= psjt_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= psjt_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			rise_q <= rise;
		end
		if (state_q == psjt_pkg::ST_DIV && div_done) begin
			// triangle fraction, falling half clamped at zero
			if (rise_q) begin
				a_q <= div_quot[F:0];
			end else if (div_quot > QW'(ONE)) begin
				a_q <= '0;
			end else begin
				a_q <= ONE - div_quot[F:0];
			end
		end
		if (state_q == psjt_pkg::ST_MUL) begin
			if (!ph_q) begin
				prod_s1 <= op_a * op_b;
			end else begin
				case (step_q)
					psjt_pkg::STEP_A2: r_q <= sh;
					psjt_pkg::STEP_A3: r_q <= sh;
					psjt_pkg::STEP_T2: t_q <= C10 + sh;
					psjt_pkg::STEP_S: begin
						if (sh < 0) begin
							s_q <= '0;
						end else if (sh > MW'(ONE)) begin
							s_q <= ONE;
						end else begin
							s_q <= sh[F:0];
						end
					end
					default: pos_q[jidx] <= sh[PW-1:0];
				endcase
			end
		end
		if (out_load) begin
			for (int i = 0; i < psjt_pkg::NUM_JOINTS; i++) begin
				out_data_q[i*PW +: PW] <= (i < JOINT_COUNT) ? pos_q[i] : '0;
			end
			out_data_q[psjt_pkg::NUM_JOINTS*PW +: psjt_pkg::FRAC_OUT_W] <= frac;
			out_data_q[psjt_pkg::OUT_TDATA_W-1] <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef ASSERT_OFF
	// divider only finishes while the sequencer waits for it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == psjt_pkg::ST_DIV)
		else $error("divider done outside divide state");

	// a new result only comes out of the output state
	a_valid_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == psjt_pkg::ST_OUT))
		else $error("result valid without output state");

	// multiply sequence never runs past the last joint
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == psjt_pkg::ST_MUL |-> step_q <= LAST)
		else $error("multiply step out of range");

	// smoothed fraction stays within one
	a_frac_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[psjt_pkg::NUM_JOINTS*PW +: psjt_pkg::FRAC_OUT_W]
			<= psjt_pkg::FRAC_OUT_W'(65536))
		else $error("smooth fraction above one");
`endif

endmodule
`default_nettype wire
